@@ rtl/core/xrrg_pkg.sv @@
// Package for the xoshiro256** range generator: widths, mixing constants,
// action codes and the command/status types between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package xrrg_pkg;

    localparam int WORD_W     = 64;
    localparam int HALF_W     = WORD_W / 2;
    localparam int FRAC_W     = 53;
    localparam int FRAC_SHIFT = WORD_W - FRAC_W;
    localparam int WORD_COUNT = 4;
    localparam int CNT_W      = $clog2(WORD_COUNT);
    localparam int DIV_CNT_W  = $clog2(WORD_W);

    localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
    localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94d049bb133111eb;

    localparam int MIX_SHIFT_0 = 30;
    localparam int MIX_SHIFT_1 = 27;
    localparam int MIX_SHIFT_2 = 31;
    localparam int ROT_OUT     = 7;
    localparam int SHL_T       = 17;
    localparam int ROT_W3      = 45;

    typedef enum logic [1:0] {
        ACT_RESEED   = 2'd0,
        ACT_FRACTION = 2'd1,
        ACT_UPPER    = 2'd2,
        ACT_RANGE    = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_MIX_ADD,
        OP_MUL_LL,
        OP_MUL_HL,
        OP_MUL_LH,
        OP_MIX_MID,
        OP_MIX_END,
        OP_ADVANCE,
        OP_SCRAMBLE,
        OP_DIV_STEP,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic use_b;
    } cmd_t;

    typedef struct packed {
        action_t act;
        logic    bad;
        logic    span_zero;
    } stat_t;

endpackage

`default_nettype wire

@@ rtl/core/xrrg_req_if.sv @@
// Request channel of the range generator: valid/ready and the request fields.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface xrrg_req_if;

    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [63:0]        seed_value;
    logic signed [63:0] lower_bound;
    logic signed [63:0] upper_bound;

    modport source (
        output valid, action, seed_value, lower_bound, upper_bound,
        input  ready
    );

    modport sink (
        input  valid, action, seed_value, lower_bound, upper_bound,
        output ready
    );

endinterface

`default_nettype wire

@@ rtl/core/xrrg_rsp_if.sv @@
// Result channel of the range generator: valid/ready and the result fields.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface xrrg_rsp_if;

    logic               valid;
    logic               ready;
    logic [52:0]        fraction;
    logic signed [63:0] draw_value;
    logic               status;

    modport source (
        output valid, fraction, draw_value, status,
        input  ready
    );

    modport sink (
        input  valid, fraction, draw_value, status,
        output ready
    );

endinterface

`default_nettype wire

@@ rtl/core/xrrg_datapath.sv @@
// Datapath: generator words, splitmix64 mixing on a shared 32x32 multiplier,
// xoshiro256** advance, serial restoring remainder and the result register.
// Depends on xrrg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xrrg_datapath (
    input  wire logic                        clk,
    input  wire xrrg_pkg::cmd_t              cmd,
    output xrrg_pkg::stat_t                  stat,
    input  wire logic [1:0]                  action,
    input  wire logic [63:0]                 seed_value,
    input  wire logic signed [63:0]          lower_bound,
    input  wire logic signed [63:0]          upper_bound,
    output logic [xrrg_pkg::FRAC_W-1:0]      fraction,
    output logic signed [xrrg_pkg::WORD_W-1:0] draw_value,
    output logic                             status
);
    import xrrg_pkg::*;

    logic [WORD_W-1:0] words_reg [WORD_COUNT];
    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] x_reg;
    logic [WORD_W-1:0] prod_reg;
    logic [WORD_W-1:0] rot_reg;
    logic [WORD_W-1:0] r_reg;
    logic [WORD_W-1:0] div_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] span_reg;
    logic [WORD_W-1:0] low_reg;
    action_t           act_reg;
    logic              bad_reg;
    logic [FRAC_W-1:0] frac_reg;
    logic [WORD_W-1:0] val_reg;
    logic              status_reg;

    logic [WORD_W-1:0] mix_const;
    logic [HALF_W-1:0] mul_a;
    logic [HALF_W-1:0] mul_b;
    logic [WORD_W-1:0] mul_p;
    logic [WORD_W-1:0] acc_sum;
    logic [WORD_W-1:0] w1_x5;
    logic [WORD_W-1:0] n0;
    logic [WORD_W-1:0] n1;
    logic [WORD_W-1:0] n2;
    logic [WORD_W-1:0] n3;
    logic [WORD_W+1:0] trial;
    logic [WORD_W-1:0] rem_shift;
    logic [WORD_W-1:0] draw_base;
    action_t           in_act;

    assign mix_const = cmd.use_b ? MIX_MUL_B : MIX_MUL_A;
    assign in_act    = action_t'(action);

    always_comb
    begin
        mul_a     = (cmd.op == OP_MUL_HL) ? x_reg[WORD_W-1:HALF_W] : x_reg[HALF_W-1:0];
        mul_b     = (cmd.op == OP_MUL_LH) ? mix_const[WORD_W-1:HALF_W]
                                          : mix_const[HALF_W-1:0];
        mul_p     = WORD_W'(mul_a) * WORD_W'(mul_b);
        acc_sum   = acc_reg + GOLDEN_STEP;
        w1_x5     = words_reg[1] + (words_reg[1] << 2);
        n2        = words_reg[2] ^ words_reg[0];
        n3        = words_reg[3] ^ words_reg[1];
        n1        = words_reg[1] ^ n2;
        n0        = words_reg[0] ^ n3;
        rem_shift = {rem_reg[WORD_W-2:0], div_reg[WORD_W-1]};
        trial     = {1'b0, rem_reg, div_reg[WORD_W-1]} - {2'b00, span_reg};
        draw_base = stat.span_zero ? r_reg : rem_reg;
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_NONE:
            begin
            end
            OP_CLEAR:
            begin
                acc_reg <= '0;
                act_reg <= ACT_RESEED;
                bad_reg <= 1'b0;
            end
            OP_LOAD:
            begin
                act_reg <= in_act;
                acc_reg <= seed_value;
                if (in_act == ACT_UPPER)
                begin
                    low_reg  <= WORD_W'(1);
                    span_reg <= upper_bound;
                    bad_reg  <= (upper_bound < 64'sd1);
                end
                else
                begin
                    low_reg  <= lower_bound;
                    span_reg <= upper_bound - lower_bound + 64'sd1;
                    bad_reg  <= (in_act == ACT_RANGE) && (upper_bound < lower_bound);
                end
            end
            OP_MIX_ADD:
            begin
                acc_reg <= acc_sum;
                x_reg   <= acc_sum ^ (acc_sum >> MIX_SHIFT_0);
            end
            OP_MUL_LL:
            begin
                prod_reg <= mul_p;
            end
            OP_MUL_HL, OP_MUL_LH:
            begin
                prod_reg <= prod_reg + {mul_p[HALF_W-1:0], {HALF_W{1'b0}}};
            end
            OP_MIX_MID:
            begin
                x_reg <= prod_reg ^ (prod_reg >> MIX_SHIFT_1);
            end
            OP_MIX_END:
            begin
                for (int i = 0; i < WORD_COUNT - 1; i++)
                begin
                    words_reg[i] <= words_reg[i+1];
                end
                words_reg[WORD_COUNT-1] <= prod_reg ^ (prod_reg >> MIX_SHIFT_2);
            end
            OP_ADVANCE:
            begin
                rot_reg      <= (w1_x5 << ROT_OUT) | (w1_x5 >> (WORD_W - ROT_OUT));
                words_reg[0] <= n0;
                words_reg[1] <= n1;
                words_reg[2] <= n2 ^ (words_reg[1] << SHL_T);
                words_reg[3] <= (n3 << ROT_W3) | (n3 >> (WORD_W - ROT_W3));
            end
            OP_SCRAMBLE:
            begin
                r_reg   <= rot_reg + (rot_reg << 3);
                div_reg <= rot_reg + (rot_reg << 3);
                rem_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                div_reg <= div_reg << 1;
                rem_reg <= trial[WORD_W+1] ? rem_shift : trial[WORD_W-1:0];
            end
            OP_EMIT:
            begin
                status_reg <= bad_reg;
                frac_reg   <= (act_reg == ACT_FRACTION) ? r_reg[WORD_W-1:FRAC_SHIFT] : '0;
                if (!bad_reg && (act_reg == ACT_UPPER || act_reg == ACT_RANGE))
                begin
                    val_reg <= draw_base + low_reg;
                end
                else
                begin
                    val_reg <= '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        stat.act       = act_reg;
        stat.bad       = bad_reg;
        stat.span_zero = (span_reg == '0);
    end

    assign fraction   = frac_reg;
    assign draw_value = $signed(val_reg);
    assign status     = status_reg;

endmodule

`default_nettype wire

@@ rtl/core/xrrg_controller.sv @@
// Controller: one-hot sequencer for boot seeding, reseed, draw and remainder
// steps, plus the result valid flag. Depends on xrrg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xrrg_controller (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    input  wire xrrg_pkg::stat_t stat,
    output xrrg_pkg::cmd_t       cmd
);
    import xrrg_pkg::*;

    typedef enum logic [15:0] {
        S_BOOT     = 16'b0000_0000_0000_0001,
        S_IDLE     = 16'b0000_0000_0000_0010,
        S_CHECK    = 16'b0000_0000_0000_0100,
        S_MIX_ADD  = 16'b0000_0000_0000_1000,
        S_MA0      = 16'b0000_0000_0001_0000,
        S_MA1      = 16'b0000_0000_0010_0000,
        S_MA2      = 16'b0000_0000_0100_0000,
        S_MIX_MID  = 16'b0000_0000_1000_0000,
        S_MB0      = 16'b0000_0001_0000_0000,
        S_MB1      = 16'b0000_0010_0000_0000,
        S_MB2      = 16'b0000_0100_0000_0000,
        S_MIX_END  = 16'b0000_1000_0000_0000,
        S_ADVANCE  = 16'b0001_0000_0000_0000,
        S_SCRAMBLE = 16'b0010_0000_0000_0000,
        S_DIV      = 16'b0100_0000_0000_0000,
        S_EMIT     = 16'b1000_0000_0000_0000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic                 boot_reg;
    logic                 boot_next;
    logic [CNT_W-1:0]     word_cnt_reg;
    logic [CNT_W-1:0]     word_cnt_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [DIV_CNT_W-1:0] div_cnt_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_BOOT;
            boot_reg      <= 1'b1;
            word_cnt_reg  <= '0;
            div_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            boot_reg      <= boot_next;
            word_cnt_reg  <= word_cnt_next;
            div_cnt_reg   <= div_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        boot_next      = boot_reg;
        word_cnt_next  = word_cnt_reg;
        div_cnt_next   = div_cnt_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        req_ready      = 1'b0;
        cmd.op         = OP_NONE;
        cmd.use_b      = 1'b0;

        unique case (state_reg)
            S_BOOT:
            begin
                cmd.op        = OP_CLEAR;
                boot_next     = 1'b1;
                word_cnt_next = '0;
                state_next    = S_MIX_ADD;
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                priority if (stat.act == ACT_RESEED)
                begin
                    word_cnt_next = '0;
                    state_next    = S_MIX_ADD;
                end
                else if (stat.bad)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_ADVANCE;
                end
            end
            S_MIX_ADD:
            begin
                cmd.op     = OP_MIX_ADD;
                state_next = S_MA0;
            end
            S_MA0:
            begin
                cmd.op     = OP_MUL_LL;
                state_next = S_MA1;
            end
            S_MA1:
            begin
                cmd.op     = OP_MUL_HL;
                state_next = S_MA2;
            end
            S_MA2:
            begin
                cmd.op     = OP_MUL_LH;
                state_next = S_MIX_MID;
            end
            S_MIX_MID:
            begin
                cmd.op     = OP_MIX_MID;
                state_next = S_MB0;
            end
            S_MB0:
            begin
                cmd.op     = OP_MUL_LL;
                cmd.use_b  = 1'b1;
                state_next = S_MB1;
            end
            S_MB1:
            begin
                cmd.op     = OP_MUL_HL;
                cmd.use_b  = 1'b1;
                state_next = S_MB2;
            end
            S_MB2:
            begin
                cmd.op     = OP_MUL_LH;
                cmd.use_b  = 1'b1;
                state_next = S_MIX_END;
            end
            S_MIX_END:
            begin
                cmd.op = OP_MIX_END;
                if (word_cnt_reg == CNT_W'(WORD_COUNT - 1))
                begin
                    boot_next  = 1'b0;
                    state_next = boot_reg ? S_IDLE : S_EMIT;
                end
                else
                begin
                    word_cnt_next = word_cnt_reg + 1'b1;
                    state_next    = S_MIX_ADD;
                end
            end
            S_ADVANCE:
            begin
                cmd.op     = OP_ADVANCE;
                state_next = S_SCRAMBLE;
            end
            S_SCRAMBLE:
            begin
                cmd.op = OP_SCRAMBLE;
                if (stat.act == ACT_FRACTION || stat.span_zero)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    div_cnt_next = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.op       = OP_DIV_STEP;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(WORD_W - 1))
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.op         = OP_EMIT;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_BOOT;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

@@ rtl/core/xoshiro_random_range_generator.sv @@
// Top level of the xoshiro256** range generator: joins controller and datapath
// to the request and result channels. Depends on xrrg_pkg, xrrg_req_if,
// xrrg_rsp_if, xrrg_controller and xrrg_datapath.
//
//   channel | dir | fields
//   --------+-----+--------------------------------------------------------
//   req     | in  | action, seed_value, lower_bound, upper_bound
//   rsp     | out | fraction, draw_value, status
//
// Reseed runs four splitmix64 steps (six partial products each on the shared
// 32x32 multiplier); ranged draws advance, scramble and then run the
// one-bit-per-cycle remainder loop; fraction and full-span requests advance
// and scramble; bad-bound requests go straight to emit. After reset the
// seed-zero expansion runs with req.ready low. A stalled result sits in the
// output register; the next request is taken meanwhile and waits in emit.
`timescale 1ns / 1ps
`default_nettype none

module xoshiro_random_range_generator (
    input  wire logic clk,
    input  wire logic rst_n,
    xrrg_req_if.sink  req,
    xrrg_rsp_if.source rsp
);
    import xrrg_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    xrrg_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    xrrg_datapath u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .stat        (stat),
        .action      (req.action),
        .seed_value  (req.seed_value),
        .lower_bound (req.lower_bound),
        .upper_bound (req.upper_bound),
        .fraction    (rsp.fraction),
        .draw_value  (rsp.draw_value),
        .status      (rsp.status)
    );

endmodule

`default_nettype wire
